// File: hdl/period_meter_adaptive_smoothing_defines.svh
// assertion macros used by the port-level checker file
`ifndef PERIOD_METER_ADAPTIVE_SMOOTHING_DEFINES_SVH
`define PERIOD_METER_ADAPTIVE_SMOOTHING_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define PMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define PMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/pms_pkg.sv
// shared types and constants of the period meter
package pms_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned FREQ_W  = 21;
    localparam int unsigned BAND_W  = 2;
    localparam int unsigned HOLD_W  = 16;
    localparam int unsigned THR_W   = 10;
    localparam int unsigned NUM_W   = 37;
    localparam int unsigned PROD_W  = THR_W + TIME_W;
    localparam int unsigned CNT_W   = $clog2(NUM_W + 1);
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = 1;
    localparam int unsigned Q_CNT_W = 2;

    // division by five, one byte of the dividend per step
    localparam int unsigned CD_W      = 40;
    localparam int unsigned CD_DIG_W  = 8;
    localparam int unsigned CD_REM_W  = 3;
    localparam int unsigned CD_V_W    = CD_REM_W + CD_DIG_W;
    localparam int unsigned CD_PROD_W = 24;
    localparam int unsigned CD_STEPS  = CD_W / CD_DIG_W;
    localparam int unsigned CD_CNT_W  = 3;
    localparam int unsigned RECIP5_SH = 14;

    localparam logic [PROD_W-1:0] HZ_NUM      = PROD_W'(1000000);
    localparam logic [NUM_W-1:0]  MILLIHZ_NUM = NUM_W'(1000000000);
    localparam logic [FREQ_W-1:0] FREQ_MAX    = '1;
    // (2^14 + 1) / 5, exact for step values below 2^14
    localparam logic [CD_PROD_W-1:0] RECIP5   = CD_PROD_W'(3277);

    localparam logic [BAND_W-1:0] BAND_RAW  = 2'd0;
    localparam logic [BAND_W-1:0] BAND_MID  = 2'd1;
    localparam logic [BAND_W-1:0] BAND_FAST = 2'd2;

    localparam logic [IDX_W-1:0] CFG_HOLDOFF = 2'd0;
    localparam logic [IDX_W-1:0] CFG_FAST    = 2'd1;
    localparam logic [IDX_W-1:0] CFG_MID     = 2'd2;

    localparam logic [HOLD_W-1:0] HOLDOFF_RST = 16'd800;
    localparam logic [THR_W-1:0]  FAST_RST    = 10'd49;
    localparam logic [THR_W-1:0]  MID_RST     = 10'd9;

    typedef struct packed {
        logic [HOLD_W-1:0] holdoff_us;
        logic [THR_W-1:0]  fast_threshold_hz;
        logic [THR_W-1:0]  mid_threshold_hz;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BAND,
        ST_SUM,
        ST_SMOOTH,
        ST_RECIP,
        ST_DONE
    } t_bstate;

endpackage

// File: hdl/pms_in_if.sv
// sample channel: level and timestamp
interface pms_in_if;
    logic                         valid;
    logic                         ready;
    logic                         level;
    logic [pms_pkg::TIME_W-1:0]   time_us;

    modport source (output valid, output level, output time_us, input ready);
    modport sink   (input valid, input level, input time_us, output ready);
endinterface

// File: hdl/pms_out_if.sv
// result channel: smoothed period, frequency and band
interface pms_out_if;
    logic                         valid;
    logic                         ready;
    logic [pms_pkg::TIME_W-1:0]   period_us;
    logic [pms_pkg::FREQ_W-1:0]   freq_millihz;
    logic [pms_pkg::BAND_W-1:0]   band;

    modport source (output valid, output period_us, output freq_millihz, output band,
                    input ready);
    modport sink   (input valid, input period_us, input freq_millihz, input band,
                    output ready);
endinterface

// File: hdl/pms_queue.sv
// two-entry queue of elapsed times between front and back
module pms_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [pms_pkg::TIME_W-1:0] i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic                       o_valid,
    output logic [pms_pkg::TIME_W-1:0] o_data
);
    logic [pms_pkg::TIME_W-1:0]  r_mem [pms_pkg::Q_DEPTH];
    logic [pms_pkg::Q_PTR_W-1:0] r_wp;
    logic [pms_pkg::Q_PTR_W-1:0] r_rp;
    logic [pms_pkg::Q_CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == pms_pkg::Q_CNT_W'(pms_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

// File: hdl/pms_front.sv
// front: edge qualification with holdoff, start mark tracking
module pms_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    pms_in_if.sink                     i_smp,
    input  logic [pms_pkg::HOLD_W-1:0] i_holdoff_us,
    input  logic                       i_q_full,
    output logic                       o_push,
    output logic [pms_pkg::TIME_W-1:0] o_elapsed
);
    logic                       r_last_level;
    logic [pms_pkg::TIME_W-1:0] r_start_mark;
    logic [pms_pkg::TIME_W-1:0] w_elapsed;
    logic                       w_take;

    assign i_smp.ready = !i_q_full;

    always_comb begin
        w_elapsed = i_smp.time_us - r_start_mark;
        w_take    = i_smp.valid && i_smp.ready && (i_smp.level != r_last_level)
                    && (w_elapsed > pms_pkg::TIME_W'(i_holdoff_us));
    end

    assign o_push    = w_take && i_smp.level;
    assign o_elapsed = w_elapsed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level <= 1'b0;
            r_start_mark <= '0;
        end else if (w_take) begin
            r_last_level <= i_smp.level;
            if (i_smp.level) begin
                r_start_mark <= i_smp.time_us + 1'b1;
            end
        end
    end
endmodule

// File: hdl/pms_div.sv
// restoring divider, one quotient bit per cycle
module pms_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pms_pkg::NUM_W-1:0]  i_dividend,
    input  logic [pms_pkg::TIME_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [pms_pkg::NUM_W-1:0]  o_quotient
);
    logic                       r_busy;
    logic                       r_done;
    logic [pms_pkg::CNT_W-1:0]  r_cnt;
    logic [pms_pkg::TIME_W-1:0] r_rem;
    logic [pms_pkg::TIME_W-1:0] r_dvs;
    logic [pms_pkg::NUM_W-1:0]  r_quo;
    logic [pms_pkg::TIME_W:0]   w_shift;
    logic [pms_pkg::TIME_W:0]   w_diff;
    logic                       w_bit;

    always_comb begin
        w_shift = {r_rem, r_quo[pms_pkg::NUM_W-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        w_bit   = (w_shift >= {1'b0, r_dvs});
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= pms_pkg::CNT_W'(pms_pkg::NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == pms_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[pms_pkg::NUM_W-2:0], w_bit};
            r_rem <= w_bit ? w_diff[pms_pkg::TIME_W-1:0] : w_shift[pms_pkg::TIME_W-1:0];
        end
    end
endmodule

// File: hdl/pms_back.sv
// back: band pick, smoothing, reciprocal and output register
module pms_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pms_pkg::t_cfg              i_cfg,
    input  logic                       i_q_valid,
    input  logic [pms_pkg::TIME_W-1:0] i_q_data,
    output logic                       o_pop,
    pms_out_if.source                  o_res
);
    pms_pkg::t_bstate             r_state;
    pms_pkg::t_bstate             n_state;
    logic [pms_pkg::TIME_W-1:0]   r_elapsed;
    logic [pms_pkg::TIME_W-1:0]   r_period;
    logic [pms_pkg::PROD_W-1:0]   r_fast_prod;
    logic [pms_pkg::PROD_W-1:0]   r_mid_prod;
    logic [pms_pkg::BAND_W-1:0]   r_band;
    logic [pms_pkg::FREQ_W-1:0]   r_freq;
    logic                         r_out_valid;
    logic [pms_pkg::TIME_W-1:0]   r_out_period;
    logic [pms_pkg::FREQ_W-1:0]   r_out_freq;
    logic [pms_pkg::BAND_W-1:0]   r_out_band;
    logic [pms_pkg::CD_W-1:0]     r_cd_num;
    logic [pms_pkg::CD_REM_W-1:0] r_cd_rem;
    logic [pms_pkg::CD_CNT_W-1:0] r_cd_cnt;

    logic [pms_pkg::BAND_W-1:0]   w_band;
    logic [pms_pkg::NUM_W-1:0]    w_p;
    logic [pms_pkg::NUM_W-1:0]    w_e;
    logic [pms_pkg::NUM_W-1:0]    w_num;
    logic                         w_load;
    logic                         w_div_start;
    logic [pms_pkg::NUM_W-1:0]    w_div_dividend;
    logic [pms_pkg::TIME_W-1:0]   w_div_divisor;
    logic                         w_div_done;
    logic [pms_pkg::NUM_W-1:0]    w_div_quo;
    logic [pms_pkg::CD_W-1:0]     w_cd_load;
    logic [pms_pkg::CD_V_W-1:0]   w_cd_v;
    logic [pms_pkg::CD_PROD_W-1:0] w_cd_prod;
    logic [pms_pkg::CD_DIG_W-1:0] w_cd_digit;
    logic [pms_pkg::CD_V_W-1:0]   w_cd_back;
    logic [pms_pkg::CD_REM_W-1:0] w_cd_rem;

    pms_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // band from the previous period, weighted sum by shift and add
    always_comb begin
        w_p = pms_pkg::NUM_W'(r_period);
        w_e = pms_pkg::NUM_W'(r_elapsed);
        if (r_period == '0) begin
            w_band = pms_pkg::BAND_RAW;
        end else if (r_fast_prod < pms_pkg::HZ_NUM) begin
            w_band = pms_pkg::BAND_FAST;
        end else if (r_mid_prod < pms_pkg::HZ_NUM) begin
            w_band = pms_pkg::BAND_MID;
        end else begin
            w_band = pms_pkg::BAND_RAW;
        end
        if (w_band == pms_pkg::BAND_FAST) begin
            w_num = (w_p << 4) + (w_p << 1) + w_p + w_e;
        end else begin
            w_num = (w_p << 3) + w_p + w_e;
        end
    end

    // divide by twenty as a shift by two then by five, by ten as a shift by one then five;
    // the division by five runs a byte per step through a reciprocal multiply
    always_comb begin
        w_cd_load  = (w_band == pms_pkg::BAND_FAST) ?
                     pms_pkg::CD_W'(w_num[pms_pkg::NUM_W-1:2]) :
                     pms_pkg::CD_W'(w_num[pms_pkg::NUM_W-1:1]);
        w_cd_v     = {r_cd_rem, r_cd_num[pms_pkg::CD_W-1 -: pms_pkg::CD_DIG_W]};
        w_cd_prod  = pms_pkg::CD_PROD_W'(w_cd_v) * pms_pkg::RECIP5;
        w_cd_digit = w_cd_prod[pms_pkg::RECIP5_SH +: pms_pkg::CD_DIG_W];
        w_cd_back  = w_cd_v - ((pms_pkg::CD_V_W'(w_cd_digit) << 2)
                               + pms_pkg::CD_V_W'(w_cd_digit));
        w_cd_rem   = w_cd_back[pms_pkg::CD_REM_W-1:0];
    end

    always_comb begin
        n_state        = r_state;
        o_pop          = 1'b0;
        w_load         = 1'b0;
        w_div_start    = 1'b0;
        w_div_dividend = '0;
        w_div_divisor  = '0;
        unique case (r_state)
            pms_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_state = pms_pkg::ST_BAND;
                end
            end
            pms_pkg::ST_BAND: begin
                n_state = pms_pkg::ST_SUM;
            end
            pms_pkg::ST_SUM: begin
                if (w_band == pms_pkg::BAND_RAW) begin
                    w_div_start    = 1'b1;
                    w_div_dividend = pms_pkg::MILLIHZ_NUM;
                    w_div_divisor  = r_elapsed;
                    n_state        = pms_pkg::ST_RECIP;
                end else begin
                    n_state        = pms_pkg::ST_SMOOTH;
                end
            end
            pms_pkg::ST_SMOOTH: begin
                if (r_cd_cnt == '0) begin
                    w_div_start    = 1'b1;
                    w_div_dividend = pms_pkg::MILLIHZ_NUM;
                    w_div_divisor  = r_cd_num[pms_pkg::TIME_W-1:0];
                    n_state        = pms_pkg::ST_RECIP;
                end
            end
            pms_pkg::ST_RECIP: begin
                if (w_div_done) begin
                    n_state = pms_pkg::ST_DONE;
                end
            end
            pms_pkg::ST_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    w_load  = 1'b1;
                    n_state = pms_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pms_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pms_pkg::ST_IDLE;
            r_period    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == pms_pkg::ST_SUM && w_band == pms_pkg::BAND_RAW) begin
                r_period <= r_elapsed;
            end else if (r_state == pms_pkg::ST_SMOOTH && r_cd_cnt == '0) begin
                r_period <= r_cd_num[pms_pkg::TIME_W-1:0];
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_elapsed <= i_q_data;
        end
        if (r_state == pms_pkg::ST_BAND) begin
            r_fast_prod <= pms_pkg::PROD_W'(i_cfg.fast_threshold_hz)
                           * pms_pkg::PROD_W'(r_period);
            r_mid_prod  <= pms_pkg::PROD_W'(i_cfg.mid_threshold_hz)
                           * pms_pkg::PROD_W'(r_period);
        end
        if (r_state == pms_pkg::ST_SUM) begin
            r_band   <= w_band;
            r_cd_num <= w_cd_load;
            r_cd_rem <= '0;
            r_cd_cnt <= pms_pkg::CD_CNT_W'(pms_pkg::CD_STEPS);
        end else if (r_state == pms_pkg::ST_SMOOTH && r_cd_cnt != '0) begin
            // quotient bytes shift in from the bottom as dividend bytes leave the top
            r_cd_num <= {r_cd_num[pms_pkg::CD_W-pms_pkg::CD_DIG_W-1:0], w_cd_digit};
            r_cd_rem <= w_cd_rem;
            r_cd_cnt <= r_cd_cnt - 1'b1;
        end
        if (r_state == pms_pkg::ST_RECIP && w_div_done) begin
            // saturate when the quotient needs more than the field width
            if (w_div_quo[pms_pkg::NUM_W-1:pms_pkg::FREQ_W] != '0) begin
                r_freq <= pms_pkg::FREQ_MAX;
            end else begin
                r_freq <= w_div_quo[pms_pkg::FREQ_W-1:0];
            end
        end
        if (w_load) begin
            r_out_period <= r_period;
            r_out_freq   <= r_freq;
            r_out_band   <= r_band;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.period_us    = r_out_period;
    assign o_res.freq_millihz = r_out_freq;
    assign o_res.band         = r_out_band;
endmodule

// File: hdl/period_meter_adaptive_smoothing.sv
// top level: reciprocal period meter with band-adaptive smoothing
//
// usage
// - i_smp carries one sample per transfer: the measured level and a free-running
//   microsecond timestamp that wraps at 2^32
// - o_res carries one result per qualified rising edge: smoothed period, its
//   reciprocal in millihertz (saturated to 21 bits) and the smoothing band
// - samples that are not a qualified rising edge give no result
// - config: i_cfg_we writes i_cfg_data to register i_cfg_idx
//   (0 holdoff_us, 1 fast_threshold_hz, 2 mid_threshold_hz, others ignored);
//   write only while the block is idle
// - throughput: the front takes one sample per cycle while the 2-entry queue
//   has room; per rising edge the back picks the band, forms the weighted sum,
//   runs the byte-serial division by ten or twenty when smoothing and one pass
//   of the serial divider, and pops the next elapsed time only once the result
//   is loaded into the output register
// - a stalled receiver holds the result in the output register; the back
//   finishes the next edge and waits, then the queue fills and i_smp.ready drops
// - reset: registers back to 800 / 49 / 9, no level seen, start mark and
//   period zero, queue and output empty
module period_meter_adaptive_smoothing (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    pms_in_if.sink                     i_smp,
    pms_out_if.source                  o_res,
    input  logic                       i_cfg_we,
    input  logic [pms_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [pms_pkg::CFG_W-1:0]  i_cfg_data
);
    pms_pkg::t_cfg              r_cfg;
    logic                       w_push;
    logic [pms_pkg::TIME_W-1:0] w_push_data;
    logic                       w_q_full;
    logic                       w_q_valid;
    logic [pms_pkg::TIME_W-1:0] w_q_data;
    logic                       w_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.holdoff_us        <= pms_pkg::HOLDOFF_RST;
            r_cfg.fast_threshold_hz <= pms_pkg::FAST_RST;
            r_cfg.mid_threshold_hz  <= pms_pkg::MID_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pms_pkg::CFG_HOLDOFF: r_cfg.holdoff_us        <= i_cfg_data;
                pms_pkg::CFG_FAST:    r_cfg.fast_threshold_hz <= i_cfg_data[pms_pkg::THR_W-1:0];
                pms_pkg::CFG_MID:     r_cfg.mid_threshold_hz  <= i_cfg_data[pms_pkg::THR_W-1:0];
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // front: qualifies edges and hands elapsed times of rising edges on
    pms_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_smp        (i_smp),
        .i_holdoff_us (r_cfg.holdoff_us),
        .i_q_full     (w_q_full),
        .o_push       (w_push),
        .o_elapsed    (w_push_data)
    );

    // decoupling queue
    pms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    // back: smoothing, reciprocal, output register
    pms_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_pop     (w_pop),
        .o_res     (o_res)
    );
endmodule

// File: hdl/pms_chk.sv
// port-level checker for the period meter, bound to the top level
`include "period_meter_adaptive_smoothing_defines.svh"

module pms_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_res_valid,
    input logic                       i_res_ready,
    input logic [pms_pkg::TIME_W-1:0] i_period_us,
    input logic [pms_pkg::FREQ_W-1:0] i_freq_millihz
);
    // a stalled result keeps its payload
    `PMS_ASSERT_NEXT(a_res_hold, i_res_valid && !i_res_ready, i_res_valid && $stable(i_period_us) && $stable(i_freq_millihz), "stalled result changed")

    // a qualified edge always has a nonzero period
    `PMS_ASSERT_NOW(a_period_nonzero, i_res_valid, i_period_us != '0, "zero period on output")

    // frequency is zero exactly when the period exceeds one thousand seconds
    `PMS_ASSERT_NOW(a_freq_zero, i_res_valid, (i_freq_millihz == '0) == (i_period_us > 32'd1000000000), "frequency and period disagree")

    // short periods saturate the frequency field
    `PMS_ASSERT_NOW(a_freq_sat, i_res_valid && (i_period_us < 32'd477), i_freq_millihz == pms_pkg::FREQ_MAX, "frequency not saturated")
endmodule

bind period_meter_adaptive_smoothing pms_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_period_us    (o_res.period_us),
    .i_freq_millihz (o_res.freq_millihz)
);
